>>> src/pcm_voice_mixer_allocator_core_defines.svh
// Assertion macros used by the mixer controller.
`ifndef PCM_VOICE_MIXER_ALLOCATOR_CORE_DEFINES_SVH
`define PCM_VOICE_MIXER_ALLOCATOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PVM_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pvm assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PVM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pvm assertion failed");

`endif

>>> src/pvm_pkg.sv
// Shared constants and controller/datapath interface types of the mixer.
package pvm_pkg;

    localparam int VOICES     = 8;
    localparam int VOICE_W    = $clog2(VOICES);
    localparam int VOICE_CW   = $clog2(VOICES + 1);
    localparam int SAMPLE_AW  = 16;
    localparam int POS_W      = 17;
    localparam int ID_W       = 8;
    localparam int TICK_W     = 32;
    localparam int SUM_W      = 20;
    localparam int MPROD_W    = 21;
    localparam int QUOT_W     = 18;
    localparam int RECIP_W    = 22;
    localparam int DIV_SHIFT  = 25;
    localparam int DIV_PROD_W = MPROD_W + RECIP_W;

    // Rounded-up reciprocal of 15 scaled by 2^25; exact floor for 21-bit dividends.
    localparam logic [RECIP_W-1:0] RECIP15 = RECIP_W'(2236963);

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(32768);

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic CFG_SFX   = 1'b0;
    localparam logic CFG_MUSIC = 1'b1;

    typedef struct packed {
        logic               capture;
        logic               mem_write;
        logic               scan_step;
        logic               alloc_set;
        logic               tick_step;
        logic               music_mul;
        logic               music_div;
        logic               finish;
        logic [VOICE_W-1:0] voice;
    } pvm_cmd_t;

    typedef struct packed {
        logic out_busy;
    } pvm_status_t;

endpackage

>>> src/pvm_ctrl.sv
// Controller state machine that sequences writes, voice allocation and mixing.
`include "pcm_voice_mixer_allocator_core_defines.svh"

module pvm_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [1:0]           command,
    input  pvm_pkg::pvm_status_t status,
    output logic                 in_stall,
    output pvm_pkg::pvm_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WRITE = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SET   = 3'd3;
    localparam logic [2:0] S_TICK  = 3'd4;
    localparam logic [2:0] S_MUL   = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0]                  state_reg, state_next;
    logic [pvm_pkg::VOICE_CW-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_stall   = 1'b1;
        cmd        = '0;
        cmd.voice  = cnt_reg[pvm_pkg::VOICE_W-1:0];
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                cnt_next = '0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    case (command)
                        pvm_pkg::CMD_WRITE: state_next = S_WRITE;
                        pvm_pkg::CMD_START: state_next = S_SCAN;
                        pvm_pkg::CMD_TICK:  state_next = S_TICK;
                        default:            state_next = S_IDLE;
                    endcase
                end
            end
            S_WRITE:
            begin
                cmd.mem_write = 1'b1;
                state_next    = S_IDLE;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (cnt_reg == pvm_pkg::VOICE_CW'(pvm_pkg::VOICES - 1))
                    state_next = S_SET;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_SET:
            begin
                cmd.alloc_set = 1'b1;
                state_next    = S_IDLE;
            end
            S_TICK:
            begin
                // The last count only drains the sample read for the final voice.
                cmd.tick_step = (cnt_reg < pvm_pkg::VOICE_CW'(pvm_pkg::VOICES));
                if (cnt_reg == pvm_pkg::VOICE_CW'(pvm_pkg::VOICES))
                    state_next = S_MUL;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_MUL:
            begin
                cmd.music_mul = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.music_div = 1'b1;
                state_next    = S_FIN;
            end
            S_FIN:
            begin
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `PVM_ASSERT_NEXT(a_tick_enters_loop, in_valid && !in_stall && command == pvm_pkg::CMD_TICK, state_reg == S_TICK && cnt_reg == '0)
    `PVM_ASSERT_NOW(a_count_in_range, 1'b1, cnt_reg <= pvm_pkg::VOICE_CW'(pvm_pkg::VOICES))
    `PVM_ASSERT_NEXT(a_alloc_returns_idle, state_reg == S_SET, state_reg == S_IDLE)

endmodule

>>> src/pvm_datapath.sv
// Datapath: sample memory, voice table, mix accumulator, music scaling, output register.
module pvm_datapath
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  pvm_pkg::pvm_cmd_t           cmd,
    output pvm_pkg::pvm_status_t        status,
    input  logic                        cfg_write,
    input  logic                        cfg_index,
    input  logic [3:0]                  cfg_data,
    input  logic [15:0]                 address,
    input  logic [7:0]                  data_byte,
    input  logic [7:0]                  sound_id,
    input  logic [15:0]                 sound_length,
    input  logic                        one_at_a_time,
    input  logic signed [15:0]          music_sample,
    input  logic                        music_active,
    input  logic                        out_stall,
    output logic                        out_valid,
    output logic signed [15:0]          mixed_sample,
    output logic                        clipped
);

    localparam int NV = pvm_pkg::VOICES;

    logic [7:0] mem [2**pvm_pkg::SAMPLE_AW];

    logic [3:0] sfx_reg, mv_reg;

    logic [15:0]              addr_reg;
    logic [7:0]               data_reg;
    logic [pvm_pkg::ID_W-1:0] id_reg;
    logic [15:0]              len_reg;
    logic                     single_reg;
    logic signed [15:0]       music_reg;
    logic                     music_on_reg;

    logic [pvm_pkg::POS_W-1:0]  pos_reg     [NV];
    logic [pvm_pkg::POS_W-1:0]  end_reg     [NV];
    logic                       busy_reg    [NV];
    logic [pvm_pkg::ID_W-1:0]   sound_reg   [NV];
    logic [pvm_pkg::TICK_W-1:0] started_reg [NV];
    logic [pvm_pkg::TICK_W-1:0] tick_reg;

    logic                       stopped_reg, found_reg;
    logic [pvm_pkg::VOICE_W-1:0] slot_reg;
    logic [pvm_pkg::TICK_W-1:0] oldest_reg;

    logic [7:0]                        rd_data_reg;
    logic                              acc_en_reg;
    logic signed [pvm_pkg::SUM_W-1:0]  sum_reg;
    logic [pvm_pkg::MPROD_W-1:0]       mprod_reg;
    logic [pvm_pkg::QUOT_W-1:0]        quot_reg;

    logic                       out_valid_reg;
    logic signed [15:0]         out_sample_reg;
    logic                       out_clip_reg;

    logic [pvm_pkg::VOICE_W-1:0] v;
    logic                        match;
    logic                        eff_busy;
    logic [pvm_pkg::POS_W-1:0]   pos_inc;
    logic signed [9:0]           centered;
    logic signed [14:0]          vprod;
    logic signed [pvm_pkg::SUM_W-1:0] vterm;
    logic [16:0]                 music_mag;
    logic [pvm_pkg::DIV_PROD_W-1:0] div_prod;
    logic signed [pvm_pkg::SUM_W-1:0] mterm;
    logic signed [pvm_pkg::SUM_W-1:0] total;
    logic signed [15:0]          sat_sample;
    logic                        sat_clip;

    assign v        = cmd.voice;
    assign match    = single_reg && !stopped_reg && busy_reg[v] && (sound_reg[v] == id_reg);
    assign eff_busy = busy_reg[v] && !match;
    assign pos_inc  = pos_reg[v] + 1'b1;

    assign centered = $signed({2'b00, rd_data_reg}) - 10'sd128;
    assign vprod    = centered * $signed({1'b0, sfx_reg});
    assign vterm    = {{(pvm_pkg::SUM_W - 18){vprod[14]}}, vprod, 3'b000};

    assign music_mag = music_reg[15] ? 17'(~{music_reg[15], music_reg} + 17'd1)
                                     : {1'b0, music_reg};
    assign div_prod  = pvm_pkg::DIV_PROD_W'(mprod_reg) * pvm_pkg::DIV_PROD_W'(pvm_pkg::RECIP15);

    always_comb
    begin
        if (!music_on_reg)
            mterm = '0;
        else if (music_reg[15])
            mterm = -$signed({2'b00, quot_reg});
        else
            mterm = $signed({2'b00, quot_reg});
        total = sum_reg + mterm;
        if (total > pvm_pkg::SAT_MAX)
        begin
            sat_sample = 16'sh7FFF;
            sat_clip   = 1'b1;
        end
        else if (total < pvm_pkg::SAT_MIN)
        begin
            sat_sample = 16'sh8000;
            sat_clip   = 1'b1;
        end
        else
        begin
            sat_sample = total[15:0];
            sat_clip   = 1'b0;
        end
    end

    // Sample memory: contents are undefined until written.
    always_ff @(posedge clk)
    begin
        if (cmd.mem_write)
            mem[addr_reg] <= data_reg;
        rd_data_reg <= mem[pos_reg[v][pvm_pkg::SAMPLE_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            addr_reg     <= address;
            data_reg     <= data_byte;
            id_reg       <= sound_id;
            len_reg      <= sound_length;
            single_reg   <= one_at_a_time;
            music_reg    <= music_sample;
            music_on_reg <= music_active && (mv_reg != 4'd0);
        end
        if (cmd.music_mul)
            mprod_reg <= {19'(19'(music_mag) * 19'(mv_reg)), 2'b00};
        if (cmd.music_div)
            quot_reg <= pvm_pkg::QUOT_W'(div_prod >> pvm_pkg::DIV_SHIFT);
        if (cmd.finish)
        begin
            out_sample_reg <= sat_sample;
            out_clip_reg   <= sat_clip;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sfx_reg       <= 4'd8;
            mv_reg        <= 4'd8;
            tick_reg      <= '0;
            stopped_reg   <= 1'b0;
            found_reg     <= 1'b0;
            slot_reg      <= '0;
            oldest_reg    <= '0;
            acc_en_reg    <= 1'b0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NV; i++)
            begin
                pos_reg[i]     <= '0;
                end_reg[i]     <= '0;
                busy_reg[i]    <= 1'b0;
                sound_reg[i]   <= '0;
                started_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == pvm_pkg::CFG_SFX)
                    sfx_reg <= cfg_data;
                else
                    mv_reg <= cfg_data;
            end

            if (cmd.capture)
            begin
                stopped_reg <= 1'b0;
                found_reg   <= 1'b0;
                slot_reg    <= '0;
                oldest_reg  <= tick_reg;
                sum_reg     <= '0;
            end

            // One voice per cycle: stop a same-id voice in one-at-a-time mode, then pick the allocation slot.
            if (cmd.scan_step)
            begin
                if (match)
                begin
                    busy_reg[v] <= 1'b0;
                    stopped_reg <= 1'b1;
                end
                if (!found_reg)
                begin
                    if (!eff_busy)
                    begin
                        slot_reg  <= v;
                        found_reg <= 1'b1;
                    end
                    else if (started_reg[v] < oldest_reg)
                    begin
                        slot_reg   <= v;
                        oldest_reg <= started_reg[v];
                    end
                end
            end

            if (cmd.alloc_set)
            begin
                pos_reg[slot_reg]     <= {1'b0, addr_reg};
                end_reg[slot_reg]     <= {1'b0, addr_reg} + {1'b0, len_reg};
                busy_reg[slot_reg]    <= 1'b1;
                sound_reg[slot_reg]   <= id_reg;
                started_reg[slot_reg] <= tick_reg;
            end

            // The byte read for a voice arrives in the next cycle and is summed then.
            acc_en_reg <= cmd.tick_step && busy_reg[v];
            if (cmd.tick_step && busy_reg[v])
            begin
                pos_reg[v] <= pos_inc;
                if (pos_inc >= end_reg[v])
                    busy_reg[v] <= 1'b0;
            end
            if (acc_en_reg)
                sum_reg <= sum_reg + vterm;

            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                tick_reg      <= tick_reg + 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_busy = out_valid_reg && out_stall;
    assign out_valid       = out_valid_reg;
    assign mixed_sample    = out_sample_reg;
    assign clipped         = out_clip_reg;

endmodule

>>> src/pcm_voice_mixer_allocator_core.sv
// Top level of the eight-voice PCM mixer with voice allocation.
//
// Input channel (in_valid / in_stall) takes one command word at a time:
// write a sample byte, start a sound on a voice, or mix one output tick.
// Only a tick produces a word on the output channel (out_valid / out_stall).
// A write stores its byte; a start scans the voices one per cycle for the
// allocation and then updates the chosen voice; a tick reads the sample memory
// port for one voice per cycle, then scales the music by volume and divides by
// fifteen in separate registered steps. in_stall stays high while a command is
// in progress. The configuration channel (cfg_valid / cfg_ready, always ready)
// writes sfx_volume at index 0 and music_volume at index 1; the user must do
// so only while the block is idle, and the block itself does not enforce it.
// Reset makes every voice idle, clears the tick counter and sets both volumes
// to 8; sample memory is not cleared and must be written before it is played.
// The result sits in an output register; while out_stall is high it holds,
// and a following tick waits at its last step until the register is free.
module pcm_voice_mixer_allocator_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         command,
    input  logic [15:0]        address,
    input  logic [7:0]         data_byte,
    input  logic [7:0]         sound_id,
    input  logic [15:0]        sound_length,
    input  logic               one_at_a_time,
    input  logic signed [15:0] music_sample,
    input  logic               music_active,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] mixed_sample,
    output logic               clipped,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [3:0]         cfg_data
);

    pvm_pkg::pvm_cmd_t    cmd;
    pvm_pkg::pvm_status_t status;

    assign cfg_ready = 1'b1;

    pvm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    pvm_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .address       (address),
        .data_byte     (data_byte),
        .sound_id      (sound_id),
        .sound_length  (sound_length),
        .one_at_a_time (one_at_a_time),
        .music_sample  (music_sample),
        .music_active  (music_active),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .mixed_sample  (mixed_sample),
        .clipped       (clipped)
    );

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the eight-voice PCM mixer with voice allocation.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_IGNORED = 2'd3;
    localparam int IDLE_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 24;

    typedef struct {
        logic signed [15:0] sample;
        logic               clip;
    } mix_word_t;

    class mixer_scoreboard;
        bit [3:0]  sfx_vol;
        bit [3:0]  mus_vol;
        bit [7:0]  mem [0:65535];
        bit        written [0:65535];
        bit [16:0] pos [pvm_pkg::VOICES];
        bit [16:0] vend [pvm_pkg::VOICES];
        bit        busy [pvm_pkg::VOICES];
        bit [7:0]  sid [pvm_pkg::VOICES];
        bit [31:0] started [pvm_pkg::VOICES];
        bit [31:0] ticks;
        mix_word_t pending [$];
        int        errors;

        function new();
            sfx_vol = 4'd8;
            mus_vol = 4'd8;
        endfunction

        function void set_volume(logic idx, logic [3:0] val);
            if (idx == pvm_pkg::CFG_SFX)
                sfx_vol = val;
            else
                mus_vol = val;
        endfunction

        function void start_voice(logic [15:0] addr, logic [7:0] id, logic [15:0] len,
                                  logic single);
            int slot;
            bit [31:0] oldest;
            slot = 0;
            oldest = ticks;
            if (single) begin
                for (int i = 0; i < pvm_pkg::VOICES; i++) begin
                    if (busy[i] && sid[i] == id) begin
                        busy[i] = 0;
                        break;
                    end
                end
            end
            // Take the first idle voice, else steal the oldest one started before now.
            for (int i = 0; i < pvm_pkg::VOICES; i++) begin
                if (!busy[i]) begin
                    slot = i;
                    break;
                end
                if (started[i] < oldest) begin
                    oldest = started[i];
                    slot = i;
                end
            end
            pos[slot] = {1'b0, addr};
            vend[slot] = {1'b0, addr} + {1'b0, len};
            busy[slot] = 1;
            sid[slot] = id;
            started[slot] = ticks;
        endfunction

        function void mix_tick(logic signed [15:0] music, logic music_on);
            int sum;
            mix_word_t w;
            sum = 0;
            for (int i = 0; i < pvm_pkg::VOICES; i++) begin
                if (busy[i]) begin
                    sum += (int'(mem[pos[i][15:0]]) - 128) * int'(sfx_vol) * 8;
                    pos[i] = pos[i] + 17'd1;
                    if (pos[i] >= vend[i])
                        busy[i] = 0;
                end
            end
            if (music_on && mus_vol != 0)
                sum += (int'(music) * int'(mus_vol) * 4) / 15;
            w.clip = 0;
            if (sum > 32767) begin
                sum = 32767;
                w.clip = 1;
            end
            if (sum < -32768) begin
                sum = -32768;
                w.clip = 1;
            end
            w.sample = sum[15:0];
            pending.push_back(w);
            ticks = ticks + 32'd1;
        endfunction

        function void note_input(logic [1:0] cmd, logic [15:0] addr, logic [7:0] data,
                                 logic [7:0] id, logic [15:0] len, logic single,
                                 logic signed [15:0] music, logic music_on);
            case (cmd)
                pvm_pkg::CMD_WRITE:
                begin
                    mem[addr] = data;
                    written[addr] = 1;
                end
                pvm_pkg::CMD_START: start_voice(addr, id, len, single);
                pvm_pkg::CMD_TICK:  mix_tick(music, music_on);
                default:   ;
            endcase
        endfunction

        function void check_output(logic signed [15:0] sample, logic clip);
            mix_word_t w;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word: sample %0d clipped %0b", $time, sample, clip);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (sample !== w.sample) begin
                $display("%0t: mixed_sample expected %0d actual %0d", $time, w.sample, sample);
                errors++;
            end
            if (clip !== w.clip) begin
                $display("%0t: clipped expected %0b actual %0b", $time, w.clip, clip);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         command;
    logic [15:0]        address;
    logic [7:0]         data_byte;
    logic [7:0]         sound_id;
    logic [15:0]        sound_length;
    logic               one_at_a_time;
    logic signed [15:0] music_sample;
    logic               music_active;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] mixed_sample;
    logic               clipped;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_index;
    logic [3:0]         cfg_data;

    mixer_scoreboard sb = new();
    bit quiet;
    int stall_left;
    int idle_cycles;

    pcm_voice_mixer_allocator_core uut (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_output(mixed_sample, clipped);
    end

    // Output backpressure comes in random bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 11);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_word(logic [1:0] cmd, logic [15:0] addr, logic [7:0] data,
                             logic [7:0] id, logic [15:0] len, logic single,
                             logic signed [15:0] music, logic music_on);
        int gap;
        in_valid <= 1'b1;
        command <= cmd;
        address <= addr;
        data_byte <= data;
        sound_id <= id;
        sound_length <= len;
        one_at_a_time <= single;
        music_sample <= music;
        music_active <= music_on;
        forever begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        sb.note_input(cmd, addr, data, id, len, single, music, music_on);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_byte(logic [15:0] addr, logic [7:0] data);
        send_word(pvm_pkg::CMD_WRITE, addr, data, 8'($urandom), 16'($urandom),
                  1'($urandom), 16'($urandom), 1'($urandom));
    endtask

    task automatic start_sound(logic [15:0] addr, logic [7:0] id, logic [15:0] len,
                               logic single);
        send_word(pvm_pkg::CMD_START, addr, 8'($urandom), id, len, single, 16'($urandom),
                  1'($urandom));
    endtask

    // Any busy voice about to read an unwritten byte gets it written first.
    task automatic mix_once(logic signed [15:0] music, logic music_on);
        for (int i = 0; i < pvm_pkg::VOICES; i++) begin
            if (sb.busy[i] && !sb.written[sb.pos[i][15:0]])
                write_byte(sb.pos[i][15:0], 8'($urandom));
        end
        send_word(pvm_pkg::CMD_TICK, 16'($urandom), 8'($urandom), 8'($urandom),
                  16'($urandom), 1'($urandom), music, music_on);
    endtask

    task automatic set_volume(logic idx, logic [3:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        forever begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        sb.set_volume(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_words(int count);
        int pick;
        logic [15:0] addr;
        logic [15:0] len;
        logic [7:0] id;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 28) begin
                addr = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 255));
                write_byte(addr, 8'($urandom));
            end else if (pick < 48) begin
                addr = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 255));
                case ($urandom_range(0, 9))
                    0:       len = 16'($urandom);
                    1:       len = 16'd0;
                    default: len = 16'($urandom_range(1, 24));
                endcase
                id = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
                start_sound(addr, id, len, 1'($urandom));
            end else if (pick < 95) begin
                mix_once(16'($urandom), 1'($urandom));
            end else begin
                send_word(CMD_IGNORED, 16'($urandom), 8'($urandom), 8'($urandom),
                          16'($urandom), 1'($urandom), 16'($urandom), 1'($urandom));
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = pvm_pkg::CMD_WRITE;
        address = '0;
        data_byte = '0;
        sound_id = '0;
        sound_length = '0;
        one_at_a_time = 1'b0;
        music_sample = '0;
        music_active = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = pvm_pkg::CFG_SFX;
        cfg_data = '0;
        quiet = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset volumes and then at full volume.
        write_byte(16'd0, 8'd255);
        write_byte(16'hFFFF, 8'd0);
        start_sound(16'hFFFF, 8'd255, 16'd0, 1'b0);
        mix_once(16'sh7FFF, 1'b1);
        mix_once(-16'sh8000, 1'b1);
        drain();
        set_volume(pvm_pkg::CFG_SFX, 4'd15);
        set_volume(pvm_pkg::CFG_MUSIC, 4'd15);
        // Nine starts in one tick fill every voice and then steal voice zero.
        for (int i = 0; i < 9; i++)
            start_sound(16'd0, 8'(i), 16'd3, 1'b0);
        start_sound(16'd0, 8'd3, 16'd0, 1'b1);
        mix_once(16'sh7FFF, 1'b1);
        mix_once(-16'sh8000, 1'b0);
        send_word(CMD_IGNORED, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b1, -16'sh1, 1'b1);
        mix_once(16'sh0, 1'b1);
        mix_once(16'sh1234, 1'b1);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0:
                begin
                    set_volume(pvm_pkg::CFG_SFX, 4'd0);
                    set_volume(pvm_pkg::CFG_MUSIC, 4'd0);
                end
                1:
                begin
                    set_volume(pvm_pkg::CFG_SFX, 4'd15);
                    set_volume(pvm_pkg::CFG_MUSIC, 4'd0);
                end
                2:
                begin
                    set_volume(pvm_pkg::CFG_SFX, 4'd1);
                    set_volume(pvm_pkg::CFG_MUSIC, 4'd15);
                end
                default:
                begin
                    set_volume(pvm_pkg::CFG_SFX, 4'($urandom));
                    set_volume(pvm_pkg::CFG_MUSIC, 4'($urandom));
                end
            endcase
            if (phase == 5)
                quiet = 1'b1;
            random_words(120);
            drain();
        end

        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/pvm_pkg.sv
src/pvm_ctrl.sv
src/pvm_datapath.sv
src/pcm_voice_mixer_allocator_core.sv
verif/tb_top.sv
